### rtl/smm_pkg.sv
`timescale 1ns / 1ps

package smm_pkg;

	localparam int DEFAULT_MAX_WINDOW  = 64;
	localparam int DEFAULT_SAMPLE_BITS = 16;

	// window length after reset, clipped to the ring depth
	localparam int WINDOW_LENGTH_RESET = 64;

	function automatic int len_bits(input int max_window);
		return $clog2(max_window + 1);
	endfunction

endpackage

### rtl/smm_if.sv
`timescale 1ns / 1ps

interface smm_in_if import smm_pkg::*; #(
	parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

interface smm_out_if import smm_pkg::*; #(
	parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS,
	parameter int MAX_WINDOW  = DEFAULT_MAX_WINDOW
);
	localparam int LEN_BITS = len_bits(MAX_WINDOW);

	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] mean;
	logic        [LEN_BITS-1:0]    fill_count;

	modport source (output valid, output mean, output fill_count, input ready);
	modport sink   (input valid, input mean, input fill_count, output ready);
endinterface

### rtl/sliding_window_mean_top.sv
`timescale 1ns / 1ps

// Moving average over the last window_length signed samples. Each accepted
// item is worked in order: take the sample and, below a full window, add it
// to the running sum; at a full window a further step reads back the oldest
// sample, subtracts it and adds the new one; then start the divider, let
// the restoring divider form the quotient, and load the output register.
// sample_ch.ready is low while an item is in work. Writing window_length
// empties the window; a value of 0 acts as 1, a value above MAX_WINDOW acts
// as MAX_WINDOW. The mean is truncated toward zero; fill_count is the
// number of samples held.
module sliding_window_mean_top import smm_pkg::*; #(
	parameter int MAX_WINDOW  = DEFAULT_MAX_WINDOW,
	parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS,
	localparam int LEN_BITS   = len_bits(MAX_WINDOW)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                window_length_we,
	input  logic [LEN_BITS-1:0] window_length,
	smm_in_if.sink              sample_ch,
	smm_out_if.source           result_ch
);

	localparam int AW       = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int SUM_BITS = SAMPLE_BITS + AW;
	localparam int RESET_LEN =
		(WINDOW_LENGTH_RESET > MAX_WINDOW) ? MAX_WINDOW : WINDOW_LENGTH_RESET;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_READ  = 5'b00010,
		S_START = 5'b00100,
		S_DIV   = 5'b01000,
		S_HOLD  = 5'b10000
	} state_t;

	state_t state_q;

	logic        [LEN_BITS-1:0]    len_q;
	logic        [LEN_BITS-1:0]    eff_len;
	logic        [AW-1:0]          oldest_q;
	logic        [LEN_BITS-1:0]    held_q;
	logic signed [SUM_BITS-1:0]    sum_q;
	logic signed [SAMPLE_BITS-1:0] sample_q;

	logic                          accept;
	logic                          full;
	logic        [LEN_BITS:0]      slot_wide;
	logic        [LEN_BITS:0]      slot_wrap;
	logic        [AW-1:0]          slot;
	logic        [LEN_BITS-1:0]    oldest_next;

	logic                          ring_we;
	logic        [AW-1:0]          ring_waddr;
	logic        [SAMPLE_BITS-1:0] ring_wdata;
	logic        [SAMPLE_BITS-1:0] ring_rdata;

	logic                          div_done;
	logic signed [SAMPLE_BITS-1:0] div_quo;

	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] mean_q;
	logic        [LEN_BITS-1:0]    fill_q;
	logic                          out_free;
	logic                          out_load;

	always_comb begin
		if (len_q == '0) begin
			eff_len = LEN_BITS'(1);
		end else if (len_q > LEN_BITS'(MAX_WINDOW)) begin
			eff_len = LEN_BITS'(MAX_WINDOW);
		end else begin
			eff_len = len_q;
		end
	end

	assign accept = sample_ch.valid && sample_ch.ready;
	assign full   = (held_q == eff_len);

	// oldest + held stays below twice the length: one compare and subtract
	assign slot_wide = (LEN_BITS + 1)'(oldest_q) + (LEN_BITS + 1)'(held_q);
	assign slot_wrap = (slot_wide >= (LEN_BITS + 1)'(eff_len))
		? slot_wide - (LEN_BITS + 1)'(eff_len) : slot_wide;
	assign slot      = slot_wrap[AW-1:0];

	assign oldest_next = LEN_BITS'(oldest_q) + 1'b1;

	assign ring_we    = (accept && !full) || (state_q == S_READ);
	assign ring_waddr = (state_q == S_READ) ? oldest_q : slot;
	assign ring_wdata = (state_q == S_READ) ? sample_q : sample_ch.sample;

	smm_ring #(
		.DEPTH (MAX_WINDOW),
		.AW    (AW),
		.WIDTH (SAMPLE_BITS)
	) u_ring (
		.clk   (clk),
		.we    (ring_we),
		.waddr (ring_waddr),
		.wdata (ring_wdata),
		.raddr (oldest_q),
		.rdata (ring_rdata)
	);

	smm_div #(
		.SUM_BITS    (SUM_BITS),
		.LEN_BITS    (LEN_BITS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_START),
		.dividend (sum_q),
		.divisor  (held_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign out_free = !out_valid_q || result_ch.ready;
	assign out_load = out_free &&
		(((state_q == S_DIV) && div_done) || (state_q == S_HOLD));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			len_q    <= LEN_BITS'(RESET_LEN);
			oldest_q <= '0;
			held_q   <= '0;
			sum_q    <= '0;
		end else begin
			if (window_length_we) begin
				len_q    <= window_length;
				oldest_q <= '0;
				held_q   <= '0;
				sum_q    <= '0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (full) begin
							state_q <= S_READ;
						end else begin
							sum_q   <= sum_q + SUM_BITS'(sample_ch.sample);
							held_q  <= held_q + 1'b1;
							state_q <= S_START;
						end
					end
				end
				S_READ: begin
					// ring_rdata holds the oldest sample, read at the accept edge
					sum_q <= sum_q - SUM_BITS'($signed(ring_rdata))
						+ SUM_BITS'(sample_q);
					oldest_q <= (oldest_next == eff_len) ? '0 : oldest_next[AW-1:0];
					state_q  <= S_START;
				end
				S_START: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= out_free ? S_IDLE : S_HOLD;
					end
				end
				S_HOLD: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= sample_ch.sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			mean_q <= div_quo;
			fill_q <= held_q;
		end
	end

	assign sample_ch.ready      = (state_q == S_IDLE);
	assign result_ch.valid      = out_valid_q;
	assign result_ch.mean       = mean_q;
	assign result_ch.fill_count = fill_q;

endmodule

### rtl/smm_ring.sv
`timescale 1ns / 1ps

module smm_ring #(
	parameter int DEPTH = 64,
	parameter int AW    = 6,
	parameter int WIDTH = 16
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/smm_div.sv
`timescale 1ns / 1ps

// Restoring divider: signed dividend by unsigned divisor, one quotient bit
// per cycle, truncation toward zero.
module smm_div #(
	parameter int SUM_BITS    = 22,
	parameter int LEN_BITS    = 7,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [SUM_BITS-1:0]    dividend,
	input  logic        [LEN_BITS-1:0]    divisor,
	output logic                          done,
	output logic signed [SAMPLE_BITS-1:0] quotient
);

	localparam int CW = (SUM_BITS > 1) ? $clog2(SUM_BITS) : 1;

	logic                busy_q;
	logic                done_q;
	logic [CW-1:0]       cnt_q;
	logic                neg_q;
	logic [LEN_BITS-1:0] div_q;
	logic [LEN_BITS-1:0] rem_q;
	logic [SUM_BITS-1:0] quo_q;

	logic [LEN_BITS:0]   trial;
	logic [LEN_BITS:0]   diff;
	logic                take;
	logic [SUM_BITS-1:0] mag;
	logic [SUM_BITS-1:0] signed_quo;

	assign mag   = dividend[SUM_BITS-1] ? (~dividend + 1'b1) : dividend;
	assign trial = {rem_q, quo_q[SUM_BITS-1]};
	assign diff  = trial - {1'b0, div_q};
	assign take  = (trial >= {1'b0, div_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(SUM_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend bits shift out the top of quo_q as quotient bits shift in
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[SUM_BITS-1];
			div_q <= divisor;
			rem_q <= '0;
			quo_q <= mag;
		end else if (busy_q) begin
			rem_q <= take ? diff[LEN_BITS-1:0] : trial[LEN_BITS-1:0];
			quo_q <= {quo_q[SUM_BITS-2:0], take};
		end
	end

	assign signed_quo = neg_q ? (~quo_q + 1'b1) : quo_q;
	assign quotient   = signed_quo[SAMPLE_BITS-1:0];
	assign done       = done_q;

endmodule
